// ===== hdl/prp_pkg.sv =====
// ----------------------------------------------------------------------------
// prp_pkg: shared types and helpers for the pairwise repulsion step
// Fixed-point widths, register indexes, divider status and saturation math.
// ----------------------------------------------------------------------------
`default_nettype none

package prp_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 31;
    localparam int IDX_W  = 2;

    localparam logic [DATA_W-1:0] S32_MAX = 32'h7FFF_FFFF;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_TIME_STEP  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FORCE_GAIN = 2'd1;
    localparam logic [IDX_W-1:0] REG_BOX_WIDTH  = 2'd2;
    localparam logic [IDX_W-1:0] REG_BOX_HEIGHT = 2'd3;

    // Divider status seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // Sign-extend a word to the 34-bit working width.
    function automatic logic signed [33:0] sext34(input logic [31:0] v);
        sext34 = $signed({{2{v[31]}}, v});
    endfunction

    // Saturate a 34-bit signed value to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        if (v > $signed({2'b00, S32_MAX}))
            sat32 = S32_MAX;
        else if (v < $signed({2'b11, ~S32_MAX}))
            sat32 = ~S32_MAX;
        else
            sat32 = v[31:0];
    endfunction

    // Magnitude of a signed word; the most negative word gives 2^31.
    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    // Give an unsigned magnitude the sign taken from a word's top bit.
    function automatic logic signed [33:0] signed_mag(input logic neg, input logic [31:0] m);
        signed_mag = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
    endfunction

endpackage

`default_nettype wire

// ===== hdl/prp_div.sv =====
// ----------------------------------------------------------------------------
// prp_div: iterative pair-force divider
// Computes min(floor(num * 2^16 / den), 2^31-1), zero for a zero divisor,
// one quotient bit per cycle after an overflow pre-check.
// ----------------------------------------------------------------------------
`default_nettype none

module prp_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [62:0]       num,
    input  wire logic [63:0]       den,
    output prp_pkg::div_sts_t      sts,
    output logic [31:0]            quo
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [64:0] rem_reg;
    logic [63:0] den_reg;
    logic [31:0] bits_reg;
    logic [31:0] quo_reg;
    logic [64:0] trial;
    logic        fits;

    // One restoring step: bring down the next numerator bit and try a subtract.
    assign trial = {rem_reg[63:0], bits_reg[31]};
    assign fits  = (trial >= {1'b0, den_reg});

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 5'd0;
                if (den == 64'd0 || {16'd0, num[62:15]} >= den)
                    done_reg <= 1'b1;
                else
                    busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, divisor and quotient shift registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg  <= den;
            rem_reg  <= {18'd0, num[62:16]};
            bits_reg <= {num[15:0], 16'd0};
            if (den == 64'd0)
                quo_reg <= 32'd0;
            else if ({16'd0, num[62:15]} >= den)
                quo_reg <= prp_pkg::S32_MAX;
            else
                quo_reg <= 32'd0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? (trial - {1'b0, den_reg}) : trial;
            quo_reg  <= {quo_reg[30:0], fits};
            bits_reg <= {bits_reg[30:0], 1'b0};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quo      = quo_reg;

endmodule

`default_nettype wire

// ===== hdl/pairwise_repulsion_particle_step_top.sv =====
// ----------------------------------------------------------------------------
// pairwise_repulsion_particle_step_top: fixed-point n-body Euler step
// Loads a batch of particles, runs one repulsion step and emits the batch.
// ----------------------------------------------------------------------------
// Loading accepts one word per cycle while idle. The word marked last starts
// a step over the n stored particles: the force store is cleared, then the
// n(n-1)/2 pairs each take two divides in the shared divider plus work on
// the shared multiplier and the store ports (a divide whose divisor is zero
// or whose quotient saturates skips the quotient-bit loop), then each
// particle is updated and each word is emitted. The input is not ready from
// the last word until the final result word is taken.
`default_nettype none

module pairwise_repulsion_particle_step_top #(
    parameter int MAX_PARTICLES = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] pos_x_in,
    input  wire logic [31:0] pos_y_in,
    input  wire logic [31:0] vel_x_in,
    input  wire logic [31:0] vel_y_in,
    input  wire logic        last_in,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      pos_x_out,
    output logic [31:0]      pos_y_out,
    output logic [31:0]      vel_x_out,
    output logic [31:0]      vel_y_out,
    output logic             last_out
);

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = $clog2(MAX_PARTICLES + 1);
    localparam logic [CW-1:0] N_MAX = CW'(MAX_PARTICLES);
    localparam logic [CW-1:0] ONE   = CW'(1);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CLR  = 5'd1;
    localparam logic [4:0] S_PRI  = 5'd2;
    localparam logic [4:0] S_PRJ  = 5'd3;
    localparam logic [4:0] S_PDIF = 5'd4;
    localparam logic [4:0] S_SQX  = 5'd5;
    localparam logic [4:0] S_SQY  = 5'd6;
    localparam logic [4:0] S_NX   = 5'd7;
    localparam logic [4:0] S_DXG  = 5'd8;
    localparam logic [4:0] S_DXW  = 5'd9;
    localparam logic [4:0] S_DYG  = 5'd10;
    localparam logic [4:0] S_DYW  = 5'd11;
    localparam logic [4:0] S_ARI  = 5'd12;
    localparam logic [4:0] S_AWI  = 5'd13;
    localparam logic [4:0] S_AWJ  = 5'd14;
    localparam logic [4:0] S_URD  = 5'd15;
    localparam logic [4:0] S_U1   = 5'd16;
    localparam logic [4:0] S_U2   = 5'd17;
    localparam logic [4:0] S_U3   = 5'd18;
    localparam logic [4:0] S_U4   = 5'd19;
    localparam logic [4:0] S_U5   = 5'd20;
    localparam logic [4:0] S_U6   = 5'd21;
    localparam logic [4:0] S_ERD  = 5'd22;
    localparam logic [4:0] S_ELD  = 5'd23;
    localparam logic [4:0] S_EWT  = 5'd24;

    // Configuration registers.
    logic [15:0] time_step_reg;
    logic [30:0] force_gain_reg;
    logic [30:0] box_width_reg;
    logic [30:0] box_height_reg;

    // Sequencer state and indexes.
    logic [4:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    logic          out_valid_reg, out_valid_next;

    // Particle and force stores with registered reads.
    logic [31:0] px_mem [MAX_PARTICLES];
    logic [31:0] py_mem [MAX_PARTICLES];
    logic [31:0] vx_mem [MAX_PARTICLES];
    logic [31:0] vy_mem [MAX_PARTICLES];
    logic [31:0] fx_mem [MAX_PARTICLES];
    logic [31:0] fy_mem [MAX_PARTICLES];
    logic [31:0] px_rd_reg, py_rd_reg, vx_rd_reg, vy_rd_reg, fx_rd_reg, fy_rd_reg;
    logic [AW-1:0] rd_addr;
    logic          pv_we;
    logic [AW-1:0] pv_waddr;
    logic [31:0]   px_wdata, py_wdata, vx_wdata, vy_wdata;
    logic          f_we;
    logic [AW-1:0] f_waddr;
    logic [31:0]   fx_wdata, fy_wdata;

    // Working registers.
    logic [31:0] pix_reg, piy_reg;
    logic [31:0] dx_reg, dy_reg;
    logic [63:0] s_reg;
    logic [31:0] fpx_reg, fpy_reg;
    logic [31:0] wpx_reg, wpy_reg, wvx_reg, wvy_reg, wfx_reg, wfy_reg;

    // Shared multiplier.
    logic        mul_en;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_reg;

    // Shared divider.
    logic              div_start;
    logic [62:0]       div_num;
    prp_pkg::div_sts_t div_sts;
    logic [31:0]       div_quo;

    // Reflected results.
    logic [31:0] rpx, rvx, rpy, rvy;
    logic        in_acc;
    logic        out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid_reg && out_ready;

    // Reflect one coordinate at most once at the wall it crossed.
    function automatic logic [63:0] reflect(input logic [31:0] p, input logic [31:0] v,
                                            input logic [30:0] w);
        logic [31:0] po;
        logic [31:0] vo;
        po = p;
        vo = v;
        if (p[31])
        begin
            po = prp_pkg::sat32(-prp_pkg::sext34(p));
            vo = prp_pkg::sat32(-prp_pkg::sext34(v));
        end
        else if (prp_pkg::sext34(p) > $signed({3'b000, w}))
        begin
            po = prp_pkg::sat32($signed({2'b00, w, 1'b0}) - prp_pkg::sext34(p));
            vo = prp_pkg::sat32(-prp_pkg::sext34(v));
        end
        reflect = {po, vo};
    endfunction

    assign {rpx, rvx} = reflect(wpx_reg, wvx_reg, box_width_reg);
    assign {rpy, rvy} = reflect(wpy_reg, wvy_reg, box_height_reg);

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg  <= 16'd6554;
            force_gain_reg <= 31'd65536;
            box_width_reg  <= 31'd655360;
            box_height_reg <= 31'd655360;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                prp_pkg::REG_TIME_STEP:  time_step_reg  <= cfg_data[15:0];
                prp_pkg::REG_FORCE_GAIN: force_gain_reg <= cfg_data;
                prp_pkg::REG_BOX_WIDTH:  box_width_reg  <= cfg_data;
                prp_pkg::REG_BOX_HEIGHT: box_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Read address follows the sequencer.
    always_comb
    begin
        unique case (state_reg)
            S_PRJ, S_AWI: rd_addr = j_reg[AW-1:0];
            S_URD, S_ERD: rd_addr = k_reg[AW-1:0];
            default:      rd_addr = i_reg[AW-1:0];
        endcase
    end

    // Store writes and registered reads.
    always_ff @(posedge clk)
    begin
        if (pv_we)
        begin
            px_mem[pv_waddr] <= px_wdata;
            py_mem[pv_waddr] <= py_wdata;
            vx_mem[pv_waddr] <= vx_wdata;
            vy_mem[pv_waddr] <= vy_wdata;
        end
        if (f_we)
        begin
            fx_mem[f_waddr] <= fx_wdata;
            fy_mem[f_waddr] <= fy_wdata;
        end
        px_rd_reg <= px_mem[rd_addr];
        py_rd_reg <= py_mem[rd_addr];
        vx_rd_reg <= vx_mem[rd_addr];
        vy_rd_reg <= vy_mem[rd_addr];
        fx_rd_reg <= fx_mem[rd_addr];
        fy_rd_reg <= fy_mem[rd_addr];
    end

    // Multiplier operand select and product register.
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = 32'd0;
        mul_b  = 32'd0;
        case (state_reg)
            S_SQX:
            begin
                mul_a = prp_pkg::mag32(dx_reg);
                mul_b = prp_pkg::mag32(dx_reg);
            end
            S_SQY:
            begin
                mul_a = prp_pkg::mag32(dy_reg);
                mul_b = prp_pkg::mag32(dy_reg);
            end
            S_NX:
            begin
                mul_a = prp_pkg::mag32(dx_reg);
                mul_b = {1'b0, force_gain_reg};
            end
            S_DXG:
            begin
                mul_a = prp_pkg::mag32(dy_reg);
                mul_b = {1'b0, force_gain_reg};
            end
            S_U1:
            begin
                mul_a = prp_pkg::mag32(fx_rd_reg);
                mul_b = {16'd0, time_step_reg};
            end
            S_U2:
            begin
                mul_a = prp_pkg::mag32(wfy_reg);
                mul_b = {16'd0, time_step_reg};
            end
            S_U3:
            begin
                mul_a = prp_pkg::mag32(wvx_reg);
                mul_b = {16'd0, time_step_reg};
            end
            S_U4:
            begin
                mul_a = prp_pkg::mag32(wvy_reg);
                mul_b = {16'd0, time_step_reg};
            end
            default: mul_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_a * mul_b;
    end

    assign div_start = (state_reg == S_DXG) || (state_reg == S_DYG);
    assign div_num   = prod_reg[62:0];

    prp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (s_reg),
        .sts   (div_sts),
        .quo   (div_quo)
    );

    // Datapath working registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_PRJ:
            begin
                pix_reg <= px_rd_reg;
                piy_reg <= py_rd_reg;
            end
            S_PDIF:
            begin
                dx_reg <= prp_pkg::sat32(prp_pkg::sext34(pix_reg) - prp_pkg::sext34(px_rd_reg));
                dy_reg <= prp_pkg::sat32(prp_pkg::sext34(piy_reg) - prp_pkg::sext34(py_rd_reg));
            end
            S_SQY: s_reg <= prod_reg;
            S_NX:  s_reg <= s_reg + prod_reg;
            S_DXW:
            begin
                if (div_sts.done)
                    fpx_reg <= dx_reg[31] ? (~div_quo + 32'd1) : div_quo;
            end
            S_DYW:
            begin
                if (div_sts.done)
                    fpy_reg <= dy_reg[31] ? (~div_quo + 32'd1) : div_quo;
            end
            S_U1:
            begin
                wpx_reg <= px_rd_reg;
                wpy_reg <= py_rd_reg;
                wvx_reg <= vx_rd_reg;
                wvy_reg <= vy_rd_reg;
                wfx_reg <= fx_rd_reg;
                wfy_reg <= fy_rd_reg;
            end
            S_U2:
                wvx_reg <= prp_pkg::sat32(prp_pkg::sext34(wvx_reg)
                           + prp_pkg::signed_mag(wfx_reg[31], prod_reg[47:16]));
            S_U3:
                wvy_reg <= prp_pkg::sat32(prp_pkg::sext34(wvy_reg)
                           + prp_pkg::signed_mag(wfy_reg[31], prod_reg[47:16]));
            S_U4:
                wpx_reg <= prp_pkg::sat32(prp_pkg::sext34(wpx_reg)
                           + prp_pkg::signed_mag(wvx_reg[31], prod_reg[47:16]));
            S_U5:
                wpy_reg <= prp_pkg::sat32(prp_pkg::sext34(wpy_reg)
                           + prp_pkg::signed_mag(wvy_reg[31], prod_reg[47:16]));
            default: ;
        endcase
    end

    // Output word register.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_ELD)
        begin
            pos_x_out <= px_rd_reg;
            pos_y_out <= py_rd_reg;
            vel_x_out <= vx_rd_reg;
            vel_y_out <= vy_rd_reg;
            last_out  <= ((k_reg + ONE) == n_reg);
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        pv_we          = 1'b0;
        pv_waddr       = k_reg[AW-1:0];
        px_wdata       = rpx;
        py_wdata       = rpy;
        vx_wdata       = rvx;
        vy_wdata       = rvy;
        f_we           = 1'b0;
        f_waddr        = k_reg[AW-1:0];
        fx_wdata       = 32'd0;
        fy_wdata       = 32'd0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if (cnt_reg < N_MAX)
                    begin
                        pv_we    = 1'b1;
                        pv_waddr = cnt_reg[AW-1:0];
                        px_wdata = pos_x_in;
                        py_wdata = pos_y_in;
                        vx_wdata = vel_x_in;
                        vy_wdata = vel_y_in;
                        cnt_next = cnt_reg + ONE;
                    end
                    if (last_in)
                    begin
                        n_next     = (cnt_reg < N_MAX) ? (cnt_reg + ONE) : cnt_reg;
                        k_next     = '0;
                        state_next = S_CLR;
                    end
                end
            end
            S_CLR:
            begin
                f_we = 1'b1;
                if ((k_reg + ONE) == n_reg)
                begin
                    k_next = '0;
                    i_next = ONE;
                    j_next = '0;
                    state_next = (n_reg == ONE) ? S_URD : S_PRI;
                end
                else
                    k_next = k_reg + ONE;
            end
            S_PRI:  state_next = S_PRJ;
            S_PRJ:  state_next = S_PDIF;
            S_PDIF: state_next = S_SQX;
            S_SQX:  state_next = S_SQY;
            S_SQY:  state_next = S_NX;
            S_NX:   state_next = S_DXG;
            S_DXG:  state_next = S_DXW;
            S_DXW:  if (div_sts.done) state_next = S_DYG;
            S_DYG:  state_next = S_DYW;
            S_DYW:  if (div_sts.done) state_next = S_ARI;
            S_ARI:  state_next = S_AWI;
            S_AWI:
            begin
                // Particle i gains the pair force.
                f_we     = 1'b1;
                f_waddr  = i_reg[AW-1:0];
                fx_wdata = prp_pkg::sat32(prp_pkg::sext34(fx_rd_reg) + prp_pkg::sext34(fpx_reg));
                fy_wdata = prp_pkg::sat32(prp_pkg::sext34(fy_rd_reg) + prp_pkg::sext34(fpy_reg));
                state_next = S_AWJ;
            end
            S_AWJ:
            begin
                // Particle j loses the same amount.
                f_we     = 1'b1;
                f_waddr  = j_reg[AW-1:0];
                fx_wdata = prp_pkg::sat32(prp_pkg::sext34(fx_rd_reg) - prp_pkg::sext34(fpx_reg));
                fy_wdata = prp_pkg::sat32(prp_pkg::sext34(fy_rd_reg) - prp_pkg::sext34(fpy_reg));
                if ((j_reg + ONE) < i_reg)
                begin
                    j_next     = j_reg + ONE;
                    state_next = S_PRI;
                end
                else
                begin
                    j_next = '0;
                    i_next = i_reg + ONE;
                    if ((i_reg + ONE) == n_reg)
                    begin
                        k_next     = '0;
                        state_next = S_URD;
                    end
                    else
                        state_next = S_PRI;
                end
            end
            S_URD: state_next = S_U1;
            S_U1:  state_next = S_U2;
            S_U2:  state_next = S_U3;
            S_U3:  state_next = S_U4;
            S_U4:  state_next = S_U5;
            S_U5:  state_next = S_U6;
            S_U6:
            begin
                pv_we = 1'b1;
                if ((k_reg + ONE) == n_reg)
                begin
                    k_next     = '0;
                    state_next = S_ERD;
                end
                else
                begin
                    k_next     = k_reg + ONE;
                    state_next = S_URD;
                end
            end
            S_ERD: state_next = S_ELD;
            S_ELD:
            begin
                out_valid_next = 1'b1;
                state_next     = S_EWT;
            end
            S_EWT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    if (last_out)
                    begin
                        cnt_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + ONE;
                        state_next = S_ERD;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // A result word is only shown while the sequencer waits for it to be taken.
    a_out_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (state_reg == S_EWT))
        else $error("output word valid outside the emit wait");

    // The divider is idle whenever a divide is started.
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_sts.busy)
        else $error("divide started while the divider is busy");

    // A divide result only arrives while the sequencer waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> (state_reg == S_DXW || state_reg == S_DYW))
        else $error("divider result arrived unexpectedly");

    // The load count never passes the store depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= N_MAX)
        else $error("load count beyond store depth");

    // Taking the final word ends the batch and resets the load count.
    a_batch_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_acc && last_out) |=> (state_reg == S_IDLE && cnt_reg == '0))
        else $error("batch not closed after final word");

endmodule

`default_nettype wire

// ===== tb/pairwise_repulsion_particle_step_top_test.sv =====
// ----------------------------------------------------------------------------
// Pairwise repulsion particle step testbench
// Loads particle batches over a valid/ready input, predicts each repulsion
// step with an in-bench fixed-point model and compares every emitted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pairwise_repulsion_particle_step_top_test;

    localparam int NPART = 32;

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] vx;
        logic [31:0] vy;
        logic        last;
    } particle_t;

    typedef struct {
        particle_t p;
        bit        typed;
        particle_t e;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] pos_x_in;
    logic [31:0] pos_y_in;
    logic [31:0] vel_x_in;
    logic [31:0] vel_y_in;
    logic        last_in;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] pos_x_out;
    logic [31:0] pos_y_out;
    logic [31:0] vel_x_out;
    logic [31:0] vel_y_out;
    logic        last_out;

    // Predictor state: configuration and particle stores.
    longint unsigned dt_q16;
    longint unsigned gain_q16;
    longint unsigned wall_x;
    longint unsigned wall_y;
    longint          sx[NPART];
    longint          sy[NPART];
    longint          svx[NPART];
    longint          svy[NPART];
    longint          fx_acc[NPART];
    longint          fy_acc[NPART];
    int unsigned     stored;

    particle_t expected_words[$];
    int        errors;
    bit        quiet;
    bit        hold_req;
    bit        typed_pending;
    particle_t typed_word;

    pairwise_repulsion_particle_step_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .pos_x_in  (pos_x_in),
        .pos_y_in  (pos_y_in),
        .vel_x_in  (vel_x_in),
        .vel_y_in  (vel_y_in),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pos_x_out (pos_x_out),
        .pos_y_out (pos_y_out),
        .vel_x_out (vel_x_out),
        .vel_y_out (vel_y_out),
        .last_out  (last_out)
    );

    // Clock with a 12 ns period.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Fixed-point helpers for the predictor.
    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint unsigned absval(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint times_dt(input longint a);
        longint unsigned m;
        m = (absval(a) * dt_q16) >> 16;
        return (a < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint repulsion(input longint d, input longint unsigned s);
        longint unsigned n;
        longint unsigned q;
        longint unsigned r;
        if (s == 0)
            return 0;
        n = absval(d) * gain_q16;
        q = n / s;
        r = n % s;
        if (q > 64'd2147483647)
        begin
            q = 64'd2147483647;
        end
        else
        begin
            for (int k = 0; k < 16; k++)
            begin
                q = q << 1;
                r = r << 1;
                if (r >= s)
                begin
                    r = r - s;
                    q = q | 64'd1;
                end
            end
            if (q > 64'd2147483647)
                q = 64'd2147483647;
        end
        return (d < 0) ? -longint'(q) : longint'(q);
    endfunction

    task automatic bounce(inout longint p, inout longint v, input longint unsigned wall);
        if (p < 0)
        begin
            p = clamp32(-p);
            v = clamp32(-v);
        end
        else if (p > longint'(wall))
        begin
            p = clamp32(2 * longint'(wall) - p);
            v = clamp32(-v);
        end
    endtask

    // Run one repulsion step over the stored batch and queue the words.
    task automatic predict_step();
        longint          dx;
        longint          dy;
        longint          fx;
        longint          fy;
        longint unsigned s;
        particle_t       w;
        for (int i = 0; i < stored; i++)
        begin
            fx_acc[i] = 0;
            fy_acc[i] = 0;
        end
        for (int i = 0; i < stored; i++)
        begin
            for (int j = 0; j < i; j++)
            begin
                dx = clamp32(sx[i] - sx[j]);
                dy = clamp32(sy[i] - sy[j]);
                s = absval(dx) * absval(dx) + absval(dy) * absval(dy);
                fx = repulsion(dx, s);
                fy = repulsion(dy, s);
                fx_acc[i] = clamp32(fx_acc[i] + fx);
                fy_acc[i] = clamp32(fy_acc[i] + fy);
                fx_acc[j] = clamp32(fx_acc[j] - fx);
                fy_acc[j] = clamp32(fy_acc[j] - fy);
            end
        end
        for (int i = 0; i < stored; i++)
        begin
            svx[i] = clamp32(svx[i] + times_dt(fx_acc[i]));
            svy[i] = clamp32(svy[i] + times_dt(fy_acc[i]));
            sx[i] = clamp32(sx[i] + times_dt(svx[i]));
            sy[i] = clamp32(sy[i] + times_dt(svy[i]));
        end
        for (int i = 0; i < stored; i++)
        begin
            bounce(sx[i], svx[i], wall_x);
            bounce(sy[i], svy[i], wall_y);
            w.px = sx[i][31:0];
            w.py = sy[i][31:0];
            w.vx = svx[i][31:0];
            w.vy = svy[i][31:0];
            w.last = (i + 1 == stored);
            expected_words.push_back(w);
        end
    endtask

    // Account for one accepted input word.
    task automatic accept_particle(input particle_t p);
        if (stored < NPART)
        begin
            sx[stored] = longint'($signed(p.px));
            sy[stored] = longint'($signed(p.py));
            svx[stored] = longint'($signed(p.vx));
            svy[stored] = longint'($signed(p.vy));
            stored++;
        end
        if (p.last)
        begin
            if (typed_pending)
            begin
                // Single-particle rows carry their result in the table.
                predict_step();
                void'(expected_words.pop_back());
                expected_words.push_back(typed_word);
                typed_pending = 1'b0;
            end
            else
            begin
                predict_step();
            end
            stored = 0;
        end
    endtask

    // Offer one word, after an occasional random gap, and hold it until accepted.
    task automatic send_particle(input particle_t p);
        int gap;
        if (!quiet && $urandom_range(99) < 17)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x_in <= p.px;
        pos_y_in <= p.py;
        vel_x_in <= p.vx;
        vel_y_in <= p.vy;
        last_in <= p.last;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        accept_particle(p);
    endtask

    task automatic release_input();
        in_valid <= 1'b0;
    endtask

    // Wait until every expected word is back, plus a short settle.
    task automatic drain();
        release_input();
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            prp_pkg::REG_TIME_STEP:  dt_q16 = value[15:0];
            prp_pkg::REG_FORCE_GAIN: gain_q16 = value;
            prp_pkg::REG_BOX_WIDTH:  wall_x = value;
            prp_pkg::REG_BOX_HEIGHT: wall_y = value;
            default: ;
        endcase
    endtask

    function automatic particle_t make_particle(input bit last);
        particle_t p;
        if ($urandom_range(99) < 70)
        begin
            p.px = $urandom_range(0, 32'hC0000) - 32'h10000;
            p.py = $urandom_range(0, 32'hC0000) - 32'h10000;
            p.vx = $urandom_range(0, 32'h80000) - 32'h40000;
            p.vy = $urandom_range(0, 32'h80000) - 32'h40000;
        end
        else
        begin
            p.px = $urandom;
            p.py = $urandom;
            p.vx = $urandom;
            p.vy = $urandom;
        end
        p.last = last;
        return p;
    endfunction

    function automatic logic [30:0] pick_cfg(input logic [30:0] top);
        case ($urandom_range(3))
            0: return '0;
            1: return top;
            default: return 31'($urandom) & top;
        endcase
    endfunction

    // Directed table; typed results only on single-particle batches.
    row_t directed[] = '{
        '{'{32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0, 1'b1}, 1'b1,
          '{32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0, 1'b1}},
        '{'{32'hFFFF_0000, 32'h0003_0000, 32'h0, 32'h0, 1'b1}, 1'b1,
          '{32'h0001_0000, 32'h0003_0000, 32'h0, 32'h0, 1'b1}},
        '{'{32'h000B_0000, 32'hFFFE_0000, 32'h0, 32'h0, 1'b1}, 1'b1,
          '{32'h0009_0000, 32'h0002_0000, 32'h0, 32'h0, 1'b1}},
        '{'{32'h0005_0000, 32'h0005_0000, 32'h0000_1000, 32'h0, 1'b0}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{32'h0005_0000, 32'h0005_0000, 32'h0, 32'hFFFF_F000, 1'b1}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0}, 1'b0,
          '{0, 0, 0, 0, 0}},
        '{'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1}, 1'b0,
          '{0, 0, 0, 0, 0}},
        '{'{32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0, 1'b0}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{32'h0001_0001, 32'h0001_0000, 32'h0, 32'h0, 1'b1}, 1'b0, '{0, 0, 0, 0, 0}},
        '{'{32'h0002_0000, 32'h0008_0000, 32'h0003_0000, 32'hFFFD_0000, 1'b0}, 1'b0,
          '{0, 0, 0, 0, 0}},
        '{'{32'h0009_8000, 32'h0000_4000, 32'h0010_0000, 32'hFFF0_0000, 1'b0}, 1'b0,
          '{0, 0, 0, 0, 0}},
        '{'{32'h0004_0000, 32'h0004_0000, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1}, 1'b0,
          '{0, 0, 0, 0, 0}}
    };

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Compare every accepted result word with the oldest expectation.
    always @(posedge clk)
    begin
        particle_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual %h %h %h %h %b",
                         $time, pos_x_out, pos_y_out, vel_x_out, vel_y_out, last_out);
                errors++;
            end
            else
            begin
                e = expected_words.pop_front();
                check_field("pos_x", e.px, pos_x_out);
                check_field("pos_y", e.py, pos_y_out);
                check_field("vel_x", e.vx, vel_x_out);
                check_field("vel_y", e.vy, vel_y_out);
                check_field("last", {31'b0, e.last}, {31'b0, last_out});
            end
        end
    end

    // Receiver: random back-pressure, one long hold-off on request.
    initial
    begin
        int held;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                for (held = 0; held < 3000; held++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 17);
        end
    end

    // Overall time limit.
    initial
    begin
        #60ms;
        $display("TEST FAILED");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        int        items;
        int        batches;
        int        len;
        particle_t p;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        pos_x_in = '0;
        pos_y_in = '0;
        vel_x_in = '0;
        vel_y_in = '0;
        last_in = 1'b0;
        errors = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        typed_pending = 1'b0;
        stored = 0;
        dt_q16 = 6554;
        gain_q16 = 65536;
        wall_x = 655360;
        wall_y = 655360;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at the reset configuration.
        foreach (directed[k])
        begin
            typed_pending = directed[k].typed;
            typed_word = directed[k].e;
            send_particle(directed[k].p);
        end
        drain();

        // Extreme step sizes and gains over a close pair.
        write_reg(prp_pkg::REG_TIME_STEP, 31'hFFFF);
        write_reg(prp_pkg::REG_FORCE_GAIN, 31'h7FFF_FFFF);
        write_reg(prp_pkg::REG_BOX_WIDTH, 31'h7FFF_FFFF);
        write_reg(prp_pkg::REG_BOX_HEIGHT, 31'h0);
        send_particle('{32'h0001_0000, 32'h0001_0000, 32'h7000_0000, 32'h0001_0000, 1'b0});
        send_particle('{32'h0001_0002, 32'h0001_0001, 32'h0, 32'h0, 1'b1});
        drain();
        write_reg(prp_pkg::REG_TIME_STEP, 31'h0);
        write_reg(prp_pkg::REG_FORCE_GAIN, 31'h0);
        send_particle('{32'h0003_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0, 1'b0});
        send_particle('{32'h0004_0000, 32'h0002_0000, 32'h0, 32'h0, 1'b1});
        drain();
        write_reg(prp_pkg::REG_TIME_STEP, 31'd6554);
        write_reg(prp_pkg::REG_FORCE_GAIN, 31'd65536);
        write_reg(prp_pkg::REG_BOX_WIDTH, 31'd655360);
        write_reg(prp_pkg::REG_BOX_HEIGHT, 31'd655360);

        // Random batches with occasional reconfiguration.
        items = 0;
        batches = 0;
        while (items < 370)
        begin
            case ($urandom_range(19))
                0:       len = $urandom_range(33, 36);
                1, 2:    len = $urandom_range(7, 16);
                default: len = $urandom_range(1, 6);
            endcase
            quiet = (items >= 150 && items < 220);
            if (batches == 10)
                hold_req = 1'b1;
            for (int n = 0; n < len; n++)
            begin
                p = make_particle(n == len - 1);
                send_particle(p);
                items++;
            end
            batches++;
            if (batches % 7 == 0)
            begin
                drain();
                write_reg(prp_pkg::REG_TIME_STEP, pick_cfg(31'hFFFF));
                write_reg(prp_pkg::REG_FORCE_GAIN,
                          ($urandom_range(1)) ? pick_cfg(31'h7FFF_FFFF)
                                              : 31'($urandom_range(0, 31'h40000)));
                write_reg(prp_pkg::REG_BOX_WIDTH,
                          ($urandom_range(1)) ? pick_cfg(31'h7FFF_FFFF)
                                              : 31'($urandom_range(0, 31'hC0000)));
                write_reg(prp_pkg::REG_BOX_HEIGHT,
                          ($urandom_range(1)) ? pick_cfg(31'h7FFF_FFFF)
                                              : 31'($urandom_range(0, 31'hC0000)));
            end
        end
        quiet = 1'b0;
        drain();
        repeat (200) @(posedge clk);

        if (errors == 0 && expected_words.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            if (expected_words.size() != 0)
                $display("%0t: %0d words never arrived", $time, expected_words.size());
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
